@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the link datapath rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ design/bpnm_pkg.sv @@
// ----------------------------------------------------------------------------
// bpnm_pkg
// types, codes and helper functions of the null modem link
// ----------------------------------------------------------------------------
package bpnm_pkg;

	localparam int FIFO_DEPTH_DEF = 4096;
	localparam int MAX_CHARS_DEF  = 31;

	localparam int SPEED_W   = 22;
	localparam int FRAME_W   = 5;
	localparam int RATE_W    = 10;
	localparam int CFG_W     = 22;
	localparam int CFG_IDX_W = 3;
	localparam int CHG_W     = 16;
	localparam int BITS_W    = 32;
	localparam int PROD_W    = 30;
	localparam int DIV_W     = 34;
	localparam int CHARS_W   = 5;
	localparam int LEN_W     = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_A   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_B   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_A   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_B   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ENDS_OPEN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE = 3'd5;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_TICK  = 2'd1;
	localparam logic [1:0] KIND_LINE  = 2'd2;

	localparam logic [1:0] OUT_WRITE = 2'd0;
	localparam logic [1:0] OUT_BYTE  = 2'd1;
	localparam logic [1:0] OUT_TICK  = 2'd2;
	localparam logic [1:0] OUT_LINE  = 2'd3;

	localparam logic [1:0] LINES_NONE = 2'b00;
	localparam logic [1:0] LINES_ALL  = 2'b11;

	localparam logic [SPEED_W-1:0] SPEED_RST = 22'd38400;
	localparam logic [FRAME_W-1:0] FRAME_RST = 5'd3;
	localparam logic [RATE_W-1:0]  RATE_RST  = 10'd100;

	// modem lines as seen from end a: bit0 rts, bit1 cts, bit2 dtr, bit3 dsr
	typedef struct packed {
		logic [3:0]            lines;
		logic [1:0][CHG_W-1:0] cts;
		logic [1:0][CHG_W-1:0] dsr;
	} modem_t;

	typedef struct packed {
		logic accept;
		logic mul;
		logic div_nom;
		logic take_nom;
		logic div_chr;
		logic take_chr;
		logic rd;
		logic emit;
		logic done;
		logic tick_end;
	} cmd_t;

	typedef struct packed {
		logic end_active;
		logic div_done;
		logic no_chars;
		logic cnt_zero;
		logic out_free;
	} stat_t;

	function automatic logic [3:0] swap_view(input logic [3:0] p);
		return {p[2], p[3], p[0], p[1]};
	endfunction

	function automatic logic [3:0] view_of(input logic [3:0] lines, input logic e);
		return e ? swap_view(lines) : lines;
	endfunction

	function automatic modem_t apply_lines(input modem_t m, input logic e,
		input logic [1:0] set, input logic [1:0] clr);
		logic [3:0] s;
		logic [3:0] c;
		logic [3:0] old;
		logic [3:0] nw;
		logic [3:0] ch;
		modem_t     r;
		s   = {1'b0, set[1], 1'b0, set[0]};
		c   = {1'b0, clr[1], 1'b0, clr[0]};
		old = view_of(m.lines, e);
		nw  = (old & ~c) | s;
		ch  = old ^ nw;
		r   = m;
		r.lines = e ? swap_view(nw) : nw;
		if (ch[0]) r.cts[~e] = r.cts[~e] + 1'b1;
		if (ch[2]) r.dsr[~e] = r.dsr[~e] + 1'b1;
		return r;
	endfunction

	// zero speed drops rts and dtr, any other speed raises them
	function automatic modem_t by_speed(input modem_t m, input logic e,
		input logic [SPEED_W-1:0] spd);
		if (spd == '0) return apply_lines(m, e, LINES_NONE, LINES_ALL);
		return apply_lines(m, e, LINES_ALL, LINES_NONE);
	endfunction

	// ten times the character length in bits
	function automatic logic [LEN_W-1:0] frame_len(input logic [FRAME_W-1:0] f);
		logic [3:0] units;
		units = 4'd7 + {2'b00, f[1:0]} + {3'b000, f[2]} + {3'b000, f[3]};
		return LEN_W'(units) * 7'd10;
	endfunction

	function automatic logic [7:0] data_mask(input logic [FRAME_W-1:0] f);
		return 8'hFF >> (2'd3 - f[1:0]);
	endfunction

endpackage

@@ design/bpnm_ram.sv @@
// ----------------------------------------------------------------------------
// bpnm_ram
// single write port, single registered read port memory
// ----------------------------------------------------------------------------
module bpnm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end
endmodule

@@ design/bpnm_div.sv @@
// ----------------------------------------------------------------------------
// bpnm_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bpnm_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [bpnm_pkg::DIV_W-1:0]   dividend,
	input  logic [bpnm_pkg::RATE_W-1:0]  divisor,
	output logic [bpnm_pkg::DIV_W-1:0]   quotient,
	output logic                         busy
);
	import bpnm_pkg::*;

	localparam int STEP_W = $clog2(DIV_W + 1);

	logic [RATE_W-1:0] rem_q;
	logic [RATE_W-1:0] dvs_q;
	logic [DIV_W-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic [RATE_W:0]   trial;
	logic              ge;

	assign trial    = {rem_q, quo_q[DIV_W-1]};
	assign ge       = trial >= {1'b0, dvs_q};
	assign quotient = quo_q;
	assign busy     = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(DIV_W);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? RATE_W'(trial - {1'b0, dvs_q}) : trial[RATE_W-1:0];
		end
	end
endmodule

@@ design/bpnm_dp.sv @@
// ----------------------------------------------------------------------------
// bpnm_dp
// link datapath: registers, fifos, credit arithmetic and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module bpnm_dp #(
	parameter int FIFO_DEPTH = bpnm_pkg::FIFO_DEPTH_DEF,
	parameter int MAX_CHARS  = bpnm_pkg::MAX_CHARS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bpnm_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [bpnm_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic [1:0]                     kind,
	input  logic                           end_sel,
	input  logic [7:0]                     data_byte,
	input  logic [7:0]                     elapsed_ticks,
	input  logic [1:0]                     set_lines,
	input  logic [1:0]                     clear_lines,
	input  bpnm_pkg::cmd_t                 cmd,
	output bpnm_pkg::stat_t                st,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [1:0]                     out_kind,
	output logic                           out_end,
	output logic [7:0]                     out_byte,
	output logic                           write_accepted,
	output logic [4:0]                     line_state,
	output logic [bpnm_pkg::CHG_W-1:0]     cts_changes,
	output logic [bpnm_pkg::CHG_W-1:0]     dsr_changes,
	output logic                           last
);
	import bpnm_pkg::*;

	localparam int PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
	localparam int ADDR_W = $clog2(2 * FIFO_DEPTH);
	localparam logic [FILL_W-1:0]  DEPTH_F = FILL_W'(FIFO_DEPTH);
	localparam logic [FILL_W:0]    DEPTH_S = (FILL_W + 1)'(FIFO_DEPTH);
	localparam logic [ADDR_W-1:0]  BASE_B  = ADDR_W'(FIFO_DEPTH);
	localparam logic [CHARS_W-1:0] MAX_C   = CHARS_W'(MAX_CHARS);

	logic [1:0][SPEED_W-1:0] speed_q;
	logic [1:0][FRAME_W-1:0] frame_q;
	logic [1:0]              open_q;
	logic [RATE_W-1:0]       rate_q;
	logic [1:0][PTR_W-1:0]   ptr_q;
	logic [1:0][FILL_W-1:0]  fill_q;
	logic [1:0][BITS_W-1:0]  nomb_q;
	logic [1:0][BITS_W-1:0]  actb_q;
	modem_t                  modem_q;
	modem_t                  modem_d;
	logic [1:0]              clr_fifo;
	logic [1:0]              clr_bits;

	logic [7:0]         elapsed_q;
	logic [PROD_W-1:0]  prod_q;
	logic [BITS_W-1:0]  nom_q;
	logic [CHARS_W-1:0] cnt_q;
	logic               deliver_q;
	logic               out_valid_q;

	logic               te;
	logic [3:0]         te_view;
	logic [RATE_W-1:0]  rate_eff;
	logic [DIV_W-1:0]   bits10;
	logic [LEN_W-1:0]   len;
	logic [BITS_W-1:0]  credit;
	logic               div_start;
	logic [DIV_W-1:0]   dividend;
	logic [RATE_W-1:0]  divisor;
	logic [DIV_W-1:0]   quotient;
	logic               div_busy;
	logic [CHARS_W-1:0] chars_d;
	logic               short_d;
	logic [CHARS_W-1:0] cnt_d;
	logic [FILL_W:0]    pos_sum;
	logic [FILL_W:0]    pos;
	logic               wr_ok;
	logic               ram_we;
	logic [ADDR_W-1:0]  waddr;
	logic [ADDR_W-1:0]  raddr;
	logic [7:0]         rdata;
	logic [3:0]         lv;
	logic               load_out;

	// line changes and fifo clears from a configuration write or a line request
	always_comb begin
		modem_d  = modem_q;
		clr_fifo = '0;
		clr_bits = '0;
		if (cfg_we) begin
			case (cfg_idx)
				CFG_SPEED_A, CFG_SPEED_B: begin
					if (cfg_wdata[SPEED_W-1:0] != speed_q[cfg_idx[0]] && open_q[cfg_idx[0]])
						modem_d = by_speed(modem_d, cfg_idx[0], cfg_wdata[SPEED_W-1:0]);
				end
				CFG_FRAME_A, CFG_FRAME_B: begin
					if (cfg_wdata[FRAME_W-1:0] != frame_q[cfg_idx[0]] && open_q[cfg_idx[0]])
						modem_d = by_speed(modem_d, cfg_idx[0], speed_q[cfg_idx[0]]);
				end
				CFG_ENDS_OPEN: begin
					for (int i = 0; i < 2; i++) begin
						if (!open_q[i] && cfg_wdata[i]) begin
							clr_fifo[i] = 1'b1;
							clr_bits[i] = 1'b1;
							modem_d = by_speed(modem_d, 1'(i), speed_q[i]);
						end else if (open_q[i] && !cfg_wdata[i]) begin
							clr_fifo[i] = 1'b1;
							modem_d = apply_lines(modem_d, 1'(i), LINES_NONE, LINES_ALL);
						end
					end
				end
				default: ;
			endcase
		end else if (cmd.accept && kind == KIND_LINE && open_q[end_sel]) begin
			modem_d = apply_lines(modem_d, end_sel, set_lines, clear_lines);
		end
	end

	// tick arithmetic for the end under service
	assign te        = cmd.tick_end;
	assign te_view   = view_of(modem_q.lines, te);
	assign rate_eff  = (rate_q == '0) ? RATE_W'(1) : rate_q;
	assign bits10    = (DIV_W'(prod_q) << 3) + (DIV_W'(prod_q) << 1);
	assign len       = frame_len(frame_q[te]);
	assign credit    = nom_q + nomb_q[te] - actb_q[te];
	assign div_start = cmd.div_nom | cmd.div_chr;
	assign dividend  = cmd.div_nom ? bits10 : DIV_W'(credit);
	assign divisor   = cmd.div_nom ? rate_eff : RATE_W'(len);
	assign chars_d   = (quotient > DIV_W'(MAX_CHARS)) ? MAX_C : quotient[CHARS_W-1:0];
	assign short_d   = FILL_W'(chars_d) > fill_q[te];
	assign cnt_d     = short_d ? fill_q[te][CHARS_W-1:0] : chars_d;

	assign st.end_active = open_q[te] && !(frame_q[te][4] && !te_view[1]);
	assign st.div_done   = !div_busy;
	assign st.no_chars   = cnt_d == '0;
	assign st.cnt_zero   = cnt_q == '0;
	assign st.out_free   = !out_valid_q || out_ready;

	bpnm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.quotient (quotient),
		.busy     (div_busy)
	);

	// fifo addressing: end b owns the upper half of the store
	assign pos_sum = (FILL_W + 1)'(ptr_q[end_sel]) + (FILL_W + 1)'(fill_q[end_sel]);
	assign pos     = (pos_sum >= DEPTH_S) ? pos_sum - DEPTH_S : pos_sum;
	assign wr_ok   = open_q[end_sel] && fill_q[end_sel] < DEPTH_F;
	assign ram_we  = cmd.accept && kind == KIND_WRITE && wr_ok;
	assign waddr   = (end_sel ? BASE_B : '0) + ADDR_W'(pos);
	assign raddr   = (te ? BASE_B : '0) + ADDR_W'(ptr_q[te]);

	bpnm_ram #(
		.WIDTH (8),
		.DEPTH (2 * FIFO_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (data_byte),
		.re    (cmd.rd),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign lv       = view_of(modem_d.lines, end_sel);
	assign load_out = (cmd.accept && (kind == KIND_WRITE || kind == KIND_LINE))
		|| (cmd.emit && deliver_q) || cmd.done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q     <= {SPEED_RST, SPEED_RST};
			frame_q     <= {FRAME_RST, FRAME_RST};
			open_q      <= '0;
			rate_q      <= RATE_RST;
			ptr_q       <= '0;
			fill_q      <= '0;
			nomb_q      <= '0;
			actb_q      <= '0;
			modem_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			modem_q <= modem_d;
			if (cfg_we) begin
				case (cfg_idx)
					CFG_SPEED_A, CFG_SPEED_B: speed_q[cfg_idx[0]] <= cfg_wdata[SPEED_W-1:0];
					CFG_FRAME_A, CFG_FRAME_B: frame_q[cfg_idx[0]] <= cfg_wdata[FRAME_W-1:0];
					CFG_ENDS_OPEN:            open_q <= cfg_wdata[1:0];
					CFG_TICK_RATE:            rate_q <= cfg_wdata[RATE_W-1:0];
					default: ;
				endcase
			end
			for (int i = 0; i < 2; i++) begin
				if (clr_fifo[i]) begin
					ptr_q[i]  <= '0;
					fill_q[i] <= '0;
				end
				if (clr_bits[i]) begin
					nomb_q[i] <= '0;
					actb_q[i] <= '0;
				end
			end
			if (ram_we) fill_q[end_sel] <= fill_q[end_sel] + 1'b1;
			if (cmd.take_chr) begin
				// a short fifo restarts both bit counters
				if (short_d) begin
					nomb_q[te] <= '0;
					actb_q[te] <= '0;
				end else begin
					nomb_q[te] <= nomb_q[te] + nom_q;
					actb_q[te] <= actb_q[te] + BITS_W'(chars_d) * BITS_W'(len);
				end
			end
			if (cmd.rd) begin
				ptr_q[te]  <= (ptr_q[te] == PTR_W'(FIFO_DEPTH - 1)) ? '0 : ptr_q[te] + 1'b1;
				fill_q[te] <= fill_q[te] - 1'b1;
			end
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) elapsed_q <= elapsed_ticks;
		if (cmd.mul) prod_q <= speed_q[te] * elapsed_q;
		if (cmd.take_nom) nom_q <= quotient[BITS_W-1:0];
		if (cmd.take_chr) begin
			cnt_q     <= cnt_d;
			deliver_q <= open_q[~te] && speed_q[0] == speed_q[1]
				&& frame_q[0][3:0] == frame_q[1][3:0];
		end else if (cmd.rd) begin
			cnt_q <= cnt_q - 1'b1;
		end
		if (load_out) begin
			out_kind       <= OUT_TICK;
			out_end        <= 1'b0;
			out_byte       <= '0;
			write_accepted <= 1'b0;
			line_state     <= '0;
			cts_changes    <= '0;
			dsr_changes    <= '0;
			last           <= 1'b1;
			if (cmd.accept && kind == KIND_WRITE) begin
				out_kind       <= OUT_WRITE;
				out_end        <= end_sel;
				write_accepted <= wr_ok;
			end else if (cmd.accept && kind == KIND_LINE) begin
				out_kind    <= OUT_LINE;
				out_end     <= end_sel;
				line_state  <= {lv[3], lv};
				cts_changes <= modem_d.cts[~end_sel];
				dsr_changes <= modem_d.dsr[~end_sel];
			end else if (cmd.emit) begin
				out_kind <= OUT_BYTE;
				out_end  <= ~te;
				out_byte <= rdata & data_mask(frame_q[te]);
				last     <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`ASSERT_ALWAYS(a_rd_has_data, clk, arst_n, !cmd.rd || fill_q[te] != '0, "drain from empty fifo")
	`ASSERT_ALWAYS(a_rd_in_count, clk, arst_n, !cmd.rd || cnt_q != '0, "drain past char count")
	`ASSERT_NEXT(a_out_loaded, clk, arst_n, load_out, out_valid_q, "result register not loaded")
	`ASSERT_ALWAYS(a_div_free, clk, arst_n, !(div_start && div_busy), "divider restarted while busy")
endmodule

@@ design/bpnm_ctrl.sv @@
// ----------------------------------------------------------------------------
// bpnm_ctrl
// request sequencer: writes and line updates taken in idle, tick walk over both ends
// ----------------------------------------------------------------------------
module bpnm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      kind,
	input  bpnm_pkg::stat_t st,
	output bpnm_pkg::cmd_t  cmd
);
	import bpnm_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_CHK, S_MUL, S_DIVN, S_WN, S_DIVC, S_WC, S_RD, S_EM, S_NEXT, S_DONE
	} state_t;

	state_t state_q;
	logic   end_q;

	always_comb begin
		in_ready     = state_q == S_IDLE && st.out_free;
		cmd          = '0;
		cmd.tick_end = end_q;
		cmd.accept   = in_valid && in_ready;
		cmd.mul      = state_q == S_MUL;
		cmd.div_nom  = state_q == S_DIVN;
		cmd.take_nom = state_q == S_WN && st.div_done;
		cmd.div_chr  = state_q == S_DIVC;
		cmd.take_chr = state_q == S_WC && st.div_done;
		cmd.rd       = state_q == S_RD;
		cmd.emit     = state_q == S_EM && st.out_free;
		cmd.done     = state_q == S_DONE && st.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			end_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.accept && kind == KIND_TICK) begin
						state_q <= S_CHK;
						end_q   <= 1'b0;
					end
				end
				S_CHK:  state_q <= st.end_active ? S_MUL : S_NEXT;
				S_MUL:  state_q <= S_DIVN;
				S_DIVN: state_q <= S_WN;
				S_WN:   if (st.div_done) state_q <= S_DIVC;
				S_DIVC: state_q <= S_WC;
				S_WC:   if (st.div_done) state_q <= st.no_chars ? S_NEXT : S_RD;
				S_RD:   state_q <= S_EM;
				S_EM:   if (st.out_free) state_q <= st.cnt_zero ? S_NEXT : S_RD;
				S_NEXT: begin
					if (end_q) begin
						state_q <= S_DONE;
					end else begin
						end_q   <= 1'b1;
						state_q <= S_CHK;
					end
				end
				S_DONE: if (st.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ design/baud_paced_null_modem_link.sv @@
// ----------------------------------------------------------------------------
// baud_paced_null_modem_link
// two crossed serial ends with transmit fifos, paced by timer tick requests
// ----------------------------------------------------------------------------
// A write or line request is taken from idle and its status result is
// registered for the next cycle, so such requests stream at one per cycle
// while no tick is in progress and results are taken. A tick request walks
// end a then end b; each open, unstopped end uses the shared bit-serial
// divider twice, first for the nominal bit count and then for the character
// count, taking each quotient once the divider is done, then drains each
// character through the store's registered read port in a read state and an
// emit state. A tick keeps the link busy until both ends are walked, and
// longer while a result waits for out_ready. The transmit store needs no clearing pass after reset.
module baud_paced_null_modem_link #(
	parameter int FIFO_DEPTH = bpnm_pkg::FIFO_DEPTH_DEF,
	parameter int MAX_CHARS  = bpnm_pkg::MAX_CHARS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bpnm_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [bpnm_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     kind,
	input  logic                           end_sel,
	input  logic [7:0]                     data_byte,
	input  logic [7:0]                     elapsed_ticks,
	input  logic [1:0]                     set_lines,
	input  logic [1:0]                     clear_lines,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     out_kind,
	output logic                           out_end,
	output logic [7:0]                     out_byte,
	output logic                           write_accepted,
	output logic [4:0]                     line_state,
	output logic [bpnm_pkg::CHG_W-1:0]     cts_changes,
	output logic [bpnm_pkg::CHG_W-1:0]     dsr_changes,
	output logic                           last
);
	import bpnm_pkg::*;

	cmd_t  cmd;
	stat_t st;

	bpnm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.st       (st),
		.cmd      (cmd)
	);

	bpnm_dp #(
		.FIFO_DEPTH (FIFO_DEPTH),
		.MAX_CHARS  (MAX_CHARS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_wdata      (cfg_wdata),
		.kind           (kind),
		.end_sel        (end_sel),
		.data_byte      (data_byte),
		.elapsed_ticks  (elapsed_ticks),
		.set_lines      (set_lines),
		.clear_lines    (clear_lines),
		.cmd            (cmd),
		.st             (st),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.out_kind       (out_kind),
		.out_end        (out_end),
		.out_byte       (out_byte),
		.write_accepted (write_accepted),
		.line_state     (line_state),
		.cts_changes    (cts_changes),
		.dsr_changes    (dsr_changes),
		.last           (last)
	);
endmodule
